### hdl/script_char_tokenizer_top_assert.svh
// assertion macros for the tokenizer checker
`ifndef SCRIPT_CHAR_TOKENIZER_TOP_ASSERT_SVH
`define SCRIPT_CHAR_TOKENIZER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SCT_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sct_pkg.sv
`default_nettype none

package sct_pkg;

    localparam int LINE_BITS   = 16;
    localparam int COLUMN_BITS = 16;
    localparam int LENGTH_BITS = 12;
    localparam int COUNT_BITS  = LENGTH_BITS + 1;
    localparam int KIND_BITS   = 3;

    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;

    // token kinds
    localparam logic [KIND_BITS-1:0] KIND_NUM   = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_IDENT = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_OP    = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_STR   = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_PUNCT = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_END   = 3'd5;

    // character codes
    localparam logic [7:0] CHAR_TAB        = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
    localparam logic [7:0] CHAR_CR         = 8'h0D;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_BANG       = 8'h21;
    localparam logic [7:0] CHAR_DQUOTE     = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE     = 8'h27;
    localparam logic [7:0] CHAR_STAR       = 8'h2A;
    localparam logic [7:0] CHAR_PLUS       = 8'h2B;
    localparam logic [7:0] CHAR_MINUS      = 8'h2D;
    localparam logic [7:0] CHAR_DOT        = 8'h2E;
    localparam logic [7:0] CHAR_SLASH      = 8'h2F;
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_NINE       = 8'h39;
    localparam logic [7:0] CHAR_LT         = 8'h3C;
    localparam logic [7:0] CHAR_EQ         = 8'h3D;
    localparam logic [7:0] CHAR_GT         = 8'h3E;
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CHAR_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]   token_kind;
        logic [LINE_BITS-1:0]   start_line;
        logic [COLUMN_BITS-1:0] start_col;
        logic [LENGTH_BITS-1:0] token_length;
        logic                   length_clipped;
        logic [7:0]             first_char;
        logic [7:0]             second_char;
        logic                   last_of_run;
    } out_item_t;

    // results of one step, handed to the output queue
    typedef struct packed {
        logic [1:0] count;
        out_item_t  r0;
        out_item_t  r1;
    } push_t;

    function automatic logic is_numeral(input logic [7:0] c);
        return c inside {[CHAR_ZERO:CHAR_NINE]};
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return c inside {[CHAR_LOWER_A:CHAR_LOWER_Z], [CHAR_UPPER_A:CHAR_UPPER_Z],
                         CHAR_UNDERSCORE};
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c inside {CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH, CHAR_EQ,
                         CHAR_LT, CHAR_GT, CHAR_BANG};
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CHAR_SPACE, CHAR_TAB, CHAR_NEWLINE, CHAR_CR};
    endfunction

    // count has one bit above the length field: that bit set means clipped
    function automatic out_item_t make_result(
        input logic [KIND_BITS-1:0]   kind,
        input logic [LINE_BITS-1:0]   line,
        input logic [COLUMN_BITS-1:0] col,
        input logic [COUNT_BITS-1:0]  count,
        input logic [7:0]             first,
        input logic [7:0]             second
    );
        out_item_t r;
        r.token_kind     = kind;
        r.start_line     = line;
        r.start_col      = col;
        r.length_clipped = count[COUNT_BITS-1];
        r.token_length   = count[COUNT_BITS-1] ? LEN_MAX : count[LENGTH_BITS-1:0];
        r.first_char     = first;
        r.second_char    = second;
        r.last_of_run    = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/sct_scan.sv
`default_nettype none

module sct_scan (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             src_valid,
    output logic                  src_stall,
    input  wire sct_pkg::in_item_t src_item,
    input  wire logic [1:0]       room,
    output sct_pkg::push_t        push
);
    import sct_pkg::*;

    typedef enum logic [5:0] {
        MODE_IDLE  = 6'b000001,
        MODE_NUM   = 6'b000010,
        MODE_IDENT = 6'b000100,
        MODE_OP    = 6'b001000,
        MODE_STR   = 6'b010000,
        MODE_ESC   = 6'b100000
    } mode_t;

    // input register
    logic     in_full_reg, in_full_next;
    in_item_t in_data_reg;

    // scanner state
    mode_t                  mode_reg, mode_next;
    logic [LINE_BITS-1:0]   cur_line_reg, cur_line_next;
    logic [COLUMN_BITS-1:0] cur_col_reg, cur_col_next;
    logic [LINE_BITS-1:0]   tok_line_reg, tok_line_next;
    logic [COLUMN_BITS-1:0] tok_col_reg, tok_col_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [7:0]             held_reg, held_next;
    logic [7:0]             quote_reg, quote_next;

    logic                   accept;
    logic                   step;
    logic [7:0]             c;
    logic                   fall;
    logic                   have_a, have_b;
    out_item_t              res_a, res_b;
    logic [1:0]             n_res;
    logic [COLUMN_BITS-1:0] col_inc;
    logic [COUNT_BITS-1:0]  count_inc;
    logic [LINE_BITS-1:0]   line_inc;
    logic [KIND_BITS-1:0]   open_kind;
    logic                   open_valid;

    assign c         = in_data_reg.char_code;
    assign col_inc   = (cur_col_reg == COL_MAX) ? cur_col_reg : cur_col_reg + 1'b1;
    assign count_inc = count_reg[COUNT_BITS-1] ? count_reg : count_reg + 1'b1;
    assign line_inc  = (cur_line_reg == LINE_MAX) ? cur_line_reg : cur_line_reg + 1'b1;

    // kind of the token open in the current mode
    always_comb
    begin
        open_valid = 1'b1;
        case (mode_reg)
            MODE_NUM:   open_kind = KIND_NUM;
            MODE_IDENT: open_kind = KIND_IDENT;
            MODE_OP:    open_kind = KIND_OP;
            MODE_STR:   open_kind = KIND_STR;
            MODE_ESC:   open_kind = KIND_STR;
            default:
            begin
                open_kind  = KIND_END;
                open_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        mode_next     = mode_reg;
        cur_line_next = cur_line_reg;
        cur_col_next  = cur_col_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        count_next    = count_reg;
        held_next     = held_reg;
        quote_next    = quote_reg;
        fall          = 1'b0;
        have_a        = 1'b0;
        have_b        = 1'b0;
        res_a = make_result(open_kind, tok_line_reg, tok_col_reg, count_reg, held_reg, 8'h00);
        res_b = make_result(KIND_PUNCT, cur_line_reg, cur_col_reg, COUNT_BITS'(1), c, 8'h00);

        if (in_data_reg.end_of_text)
        begin
            // flush, end token, back to reset values
            have_a        = open_valid;
            have_b        = 1'b1;
            res_b = make_result(KIND_END, cur_line_reg, cur_col_reg, '0, 8'h00, 8'h00);
            mode_next     = MODE_IDLE;
            cur_line_next = LINE_BITS'(1);
            cur_col_next  = '0;
            tok_line_next = LINE_BITS'(1);
            tok_col_next  = '0;
            count_next    = '0;
            held_next     = 8'h00;
            quote_next    = 8'h00;
        end
        else
        begin
            case (mode_reg)
                MODE_NUM:
                begin
                    if (is_numeral(c) || c == CHAR_DOT)
                    begin
                        count_next   = count_inc;
                        cur_col_next = col_inc;
                    end
                    else
                    begin
                        have_a = 1'b1;
                        fall   = 1'b1;
                    end
                end
                MODE_IDENT:
                begin
                    if (is_word_char(c) || is_numeral(c))
                    begin
                        count_next   = count_inc;
                        cur_col_next = col_inc;
                    end
                    else
                    begin
                        have_a = 1'b1;
                        fall   = 1'b1;
                    end
                end
                MODE_OP:
                begin
                    mode_next = MODE_IDLE;
                    have_a    = 1'b1;
                    if (is_op(c))
                    begin
                        // two-character operator
                        res_a = make_result(KIND_OP, tok_line_reg, tok_col_reg, count_inc,
                                            held_reg, c);
                        count_next   = count_inc;
                        cur_col_next = col_inc;
                    end
                    else
                    begin
                        fall = 1'b1;
                    end
                end
                MODE_STR:
                begin
                    cur_col_next = col_inc;
                    if (c == quote_reg)
                    begin
                        have_a    = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            held_next = c;
                        end
                        count_next = count_inc;
                        if (c == CHAR_BACKSLASH)
                        begin
                            mode_next = MODE_ESC;
                        end
                    end
                end
                MODE_ESC:
                begin
                    count_next   = count_inc;
                    cur_col_next = col_inc;
                    mode_next    = MODE_STR;
                end
                default:
                begin
                    fall = 1'b1;
                end
            endcase

            // character seen with no token open
            if (fall)
            begin
                mode_next = MODE_IDLE;
                if (is_blank(c))
                begin
                    if (c == CHAR_NEWLINE)
                    begin
                        cur_line_next = line_inc;
                        cur_col_next  = '0;
                    end
                    else
                    begin
                        cur_col_next = col_inc;
                    end
                end
                else if (is_numeral(c) || is_word_char(c) || is_op(c))
                begin
                    if (is_numeral(c))
                    begin
                        mode_next = MODE_NUM;
                    end
                    else if (is_word_char(c))
                    begin
                        mode_next = MODE_IDENT;
                    end
                    else
                    begin
                        mode_next = MODE_OP;
                    end
                    tok_line_next = cur_line_reg;
                    tok_col_next  = cur_col_reg;
                    count_next    = COUNT_BITS'(1);
                    held_next     = c;
                    cur_col_next  = col_inc;
                end
                else if (c == CHAR_DQUOTE || c == CHAR_SQUOTE)
                begin
                    // a string starts at the column just after its opening quote
                    mode_next     = MODE_STR;
                    quote_next    = c;
                    tok_line_next = cur_line_reg;
                    tok_col_next  = col_inc;
                    count_next    = '0;
                    held_next     = 8'h00;
                    cur_col_next  = col_inc;
                end
                else
                begin
                    have_b       = 1'b1;
                    cur_col_next = col_inc;
                end
            end
        end
    end

    assign n_res = {1'b0, have_a} + {1'b0, have_b};

    // step only when the queue has room for every result of this item
    assign step      = in_full_reg && (n_res <= room);
    assign src_stall = in_full_reg && !step;
    assign accept    = src_valid && !src_stall;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (accept)
        begin
            in_full_next = 1'b1;
        end
        else if (step)
        begin
            in_full_next = 1'b0;
        end
    end

    // pack results, last flag on the final one
    always_comb
    begin
        push.count = step ? n_res : 2'd0;
        push.r0    = have_a ? res_a : res_b;
        push.r1    = res_b;
        push.r0.last_of_run = !(have_a && have_b);
        push.r1.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            mode_reg     <= MODE_IDLE;
            cur_line_reg <= LINE_BITS'(1);
            cur_col_reg  <= '0;
            tok_line_reg <= LINE_BITS'(1);
            tok_col_reg  <= '0;
            count_reg    <= '0;
            held_reg     <= 8'h00;
            quote_reg    <= 8'h00;
        end
        else
        begin
            in_full_reg <= in_full_next;
            if (step)
            begin
                mode_reg     <= mode_next;
                cur_line_reg <= cur_line_next;
                cur_col_reg  <= cur_col_next;
                tok_line_reg <= tok_line_next;
                tok_col_reg  <= tok_col_next;
                count_reg    <= count_next;
                held_reg     <= held_next;
                quote_reg    <= quote_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= src_item;
        end
    end

endmodule

`default_nettype wire

### hdl/sct_out_queue.sv
`default_nettype none

module sct_out_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sct_pkg::push_t    push,
    output logic [1:0]             room,
    output logic                   tok_valid,
    input  wire logic              tok_stall,
    output sct_pkg::out_item_t     tok_item
);
    import sct_pkg::*;

    out_item_t  q0_reg, q0_next;
    out_item_t  q1_reg, q1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;
    logic [1:0] rem;

    assign tok_valid = (cnt_reg != 2'd0);
    assign tok_item  = q0_reg;
    assign pop       = tok_valid && !tok_stall;
    assign rem       = cnt_reg - {1'b0, pop};
    assign room      = 2'd2 - rem;

    always_comb
    begin
        // entries left after the pop, then the new results behind them
        q0_next  = (rem != 2'd0) ? (pop ? q1_reg : q0_reg) : push.r0;
        q1_next  = (rem == 2'd2) ? q1_reg : ((rem == 2'd1) ? push.r0 : push.r1);
        cnt_next = rem + push.count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

`default_nettype wire

### hdl/script_char_tokenizer_top.sv
// Script character tokenizer. Source text enters one character per item on the src channel
// and token descriptors leave on the tok channel: numbers, identifiers, one- or two-character
// operators, quoted strings and single-character punctuation, each with its start line and
// column, its length (saturating, with a clip flag) and its first characters. An item with
// end_of_text set flushes any open token, emits an end token and returns the block to its
// reset state. A character is taken every clock while the scanner is not stalled: it is held in
// the input register, then the scanner decides the mode change combinationally and writes its
// results into a two-entry output queue, so a token is offered on tok once the character that
// closes it has passed the input register and been written into the queue.
// A character that closes one token and is punctuation itself (or an end mark after an open
// token) gives two tokens; the queue drains one token per clock while tok_stall is low, so
// such an item can hold the src side until both fit. The src side also waits while tok_stall
// keeps the queue full.
`default_nettype none

module script_char_tokenizer_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // source characters
    input  wire logic               src_valid,
    output logic                    src_stall,
    input  wire sct_pkg::in_item_t  src_item,
    // token descriptors
    output logic                    tok_valid,
    input  wire logic               tok_stall,
    output sct_pkg::out_item_t      tok_item
);
    import sct_pkg::*;

    // results of one scanner step and the free room left in the queue
    push_t      push;
    logic [1:0] room;

    // input register, mode state and position counters
    sct_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .room      (room),
        .push      (push)
    );

    // result register: two entries, one token leaves per clock unless tok_stall is set
    sct_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_item  (tok_item)
    );

endmodule

`default_nettype wire

### hdl/sct_checker.sv
`default_nettype none

`include "script_char_tokenizer_top_assert.svh"

module sct_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              tok_valid,
    input  wire logic              tok_stall,
    input  wire sct_pkg::out_item_t tok_item
);
    import sct_pkg::*;

    // a stalled token stays put
    `SCT_ASSERT_NEXT(a_tok_hold, tok_valid && tok_stall, tok_valid && $stable(tok_item), "token changed while stalled")

    // the end token closes its run and carries an empty body
    `SCT_ASSERT_IMPLY(a_end_shape, tok_valid && tok_item.token_kind == KIND_END, tok_item.last_of_run && tok_item.token_length == '0 && tok_item.first_char == 8'h00, "malformed end token")

    // only strings and end tokens may have an empty body
    `SCT_ASSERT_IMPLY(a_nonempty, tok_valid && tok_item.token_kind != KIND_STR && tok_item.token_kind != KIND_END, tok_item.token_length != '0, "empty non-string token")

    // a clipped length reads as the maximum
    `SCT_ASSERT_IMPLY(a_clip, tok_valid && tok_item.length_clipped, tok_item.token_length == LEN_MAX, "clipped length not saturated")

    // only operators carry a second character
    `SCT_ASSERT_IMPLY(a_second, tok_valid && tok_item.token_kind != KIND_OP, tok_item.second_char == 8'h00, "second character on non-operator")

endmodule

bind script_char_tokenizer_top sct_checker u_sct_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_item  (tok_item)
);

`default_nettype wire

### tb/script_char_tokenizer_top_test.sv
`timescale 1ns / 1ps

module script_char_tokenizer_top_test;
    import sct_pkg::*;

    // scanner states of the local tokenizer model
    typedef enum logic [2:0] {
        LEX_IDLE,
        LEX_NUMBER,
        LEX_NAME,
        LEX_OPER,
        LEX_QUOTED,
        LEX_ESCAPE
    } lex_state_t;

    // upper bound on the length of the run, checked by the watchdog
    localparam int CYCLE_LIMIT  = 200_000;
    // a token leaves after its closing character passes the input register and the queue, plus queue slack
    localparam int DRAIN_CYCLES = 20;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_stall;
    in_item_t  src_item  = '0;
    logic      tok_valid;
    logic      tok_stall = 1'b0;
    out_item_t tok_item;

    // random idling on both channels while set
    logic idling = 1'b0;
    int   hold_left = 0;

    int chars_sent     = 0;
    int tokens_checked = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    // local copy of the tokenizer state
    lex_state_t             lex_state;
    logic [LINE_BITS-1:0]   pos_line;
    logic [COLUMN_BITS-1:0] pos_col;
    logic [LINE_BITS-1:0]   tok_line;
    logic [COLUMN_BITS-1:0] tok_col;
    logic [COUNT_BITS-1:0]  tok_len;
    logic [7:0]             tok_first;
    logic [7:0]             quote_char;

    // descriptors still owed by the block, oldest first
    out_item_t expected_tokens[$];

    script_char_tokenizer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_item  (tok_item)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // character classes
    // ------------------------------------------------------------------
    function automatic logic char_is_digit(input logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic logic char_is_letter(input logic [7:0] c);
        return (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
               (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) || c == CHAR_UNDERSCORE;
    endfunction

    function automatic logic char_is_op(input logic [7:0] c);
        return c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_STAR || c == CHAR_SLASH ||
               c == CHAR_EQ || c == CHAR_LT || c == CHAR_GT || c == CHAR_BANG;
    endfunction

    function automatic logic char_is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_NEWLINE || c == CHAR_CR;
    endfunction

    // ------------------------------------------------------------------
    // tokenizer model
    // ------------------------------------------------------------------
    // the length counter runs one past the field maximum; its top bit is the clip flag
    function automatic out_item_t token_desc(
        input logic [KIND_BITS-1:0]   kind,
        input logic [LINE_BITS-1:0]   line,
        input logic [COLUMN_BITS-1:0] col,
        input logic [COUNT_BITS-1:0]  len,
        input logic [7:0]             first,
        input logic [7:0]             second
    );
        out_item_t d;
        d.token_kind     = kind;
        d.start_line     = line;
        d.start_col      = col;
        d.length_clipped = len[COUNT_BITS-1];
        d.token_length   = len[COUNT_BITS-1] ? {LENGTH_BITS{1'b1}} : len[LENGTH_BITS-1:0];
        d.first_char     = first;
        d.second_char    = second;
        d.last_of_run    = 1'b0;
        return d;
    endfunction

    function automatic out_item_t open_token(input logic [KIND_BITS-1:0] kind);
        return token_desc(kind, tok_line, tok_col, tok_len, tok_first, 8'h00);
    endfunction

    function automatic void clear_lexer();
        lex_state  = LEX_IDLE;
        pos_line   = LINE_BITS'(1);
        pos_col    = '0;
        tok_line   = LINE_BITS'(1);
        tok_col    = '0;
        tok_len    = '0;
        tok_first  = '0;
        quote_char = '0;
    endfunction

    function automatic void col_step();
        if (pos_col < COL_MAX)
            pos_col++;
    endfunction

    function automatic void len_step();
        if (!tok_len[COUNT_BITS-1])
            tok_len++;
    endfunction

    function automatic void begin_token(input lex_state_t st, input logic [7:0] c);
        lex_state = st;
        tok_line  = pos_line;
        tok_col   = pos_col;
        tok_len   = COUNT_BITS'(1);
        tok_first = c;
        col_step();
    endfunction

    // advance the model by one accepted item and queue the descriptors it causes
    function automatic void tokenize_char(input in_item_t it);
        out_item_t  found[$];
        logic [7:0] c;
        logic       from_idle;
        c = it.char_code;
        from_idle = 1'b0;
        if (it.end_of_text)
        begin
            // flush whatever is open, then the end token, then back to reset state
            case (lex_state)
                LEX_NUMBER:             found.push_back(open_token(KIND_NUM));
                LEX_NAME:               found.push_back(open_token(KIND_IDENT));
                LEX_OPER:               found.push_back(open_token(KIND_OP));
                LEX_QUOTED, LEX_ESCAPE: found.push_back(open_token(KIND_STR));
                default:                ;
            endcase
            found.push_back(token_desc(KIND_END, pos_line, pos_col, '0, 8'h00, 8'h00));
            clear_lexer();
        end
        else
        begin
            case (lex_state)
                LEX_NUMBER:
                    if (char_is_digit(c) || c == CHAR_DOT)
                    begin
                        len_step();
                        col_step();
                    end
                    else
                    begin
                        found.push_back(open_token(KIND_NUM));
                        from_idle = 1'b1;
                    end
                LEX_NAME:
                    if (char_is_letter(c) || char_is_digit(c))
                    begin
                        len_step();
                        col_step();
                    end
                    else
                    begin
                        found.push_back(open_token(KIND_IDENT));
                        from_idle = 1'b1;
                    end
                LEX_OPER:
                begin
                    lex_state = LEX_IDLE;
                    if (char_is_op(c))
                    begin
                        // two-character operator closes at once
                        len_step();
                        found.push_back(token_desc(KIND_OP, tok_line, tok_col, tok_len,
                                                   tok_first, c));
                        col_step();
                    end
                    else
                    begin
                        found.push_back(open_token(KIND_OP));
                        from_idle = 1'b1;
                    end
                end
                LEX_QUOTED:
                    if (c == quote_char)
                    begin
                        found.push_back(open_token(KIND_STR));
                        col_step();
                        lex_state = LEX_IDLE;
                    end
                    else
                    begin
                        // newline inside a string only moves the column
                        if (tok_len == 0)
                            tok_first = c;
                        len_step();
                        col_step();
                        if (c == CHAR_BACKSLASH)
                            lex_state = LEX_ESCAPE;
                    end
                LEX_ESCAPE:
                begin
                    len_step();
                    col_step();
                    lex_state = LEX_QUOTED;
                end
                default:
                    from_idle = 1'b1;
            endcase

            if (from_idle)
            begin
                lex_state = LEX_IDLE;
                if (c == CHAR_NEWLINE)
                begin
                    if (pos_line < LINE_MAX)
                        pos_line++;
                    pos_col = '0;
                end
                else if (char_is_blank(c))
                    col_step();
                else if (char_is_digit(c))
                    begin_token(LEX_NUMBER, c);
                else if (char_is_letter(c))
                    begin_token(LEX_NAME, c);
                else if (char_is_op(c))
                    begin_token(LEX_OPER, c);
                else if (c == CHAR_DQUOTE || c == CHAR_SQUOTE)
                begin
                    // string position is the column just after the opening quote
                    col_step();
                    lex_state  = LEX_QUOTED;
                    quote_char = c;
                    tok_line   = pos_line;
                    tok_col    = pos_col;
                    tok_len    = '0;
                    tok_first  = '0;
                end
                else
                begin
                    found.push_back(token_desc(KIND_PUNCT, pos_line, pos_col,
                                               COUNT_BITS'(1), c, 8'h00));
                    col_step();
                end
            end
        end

        if (found.size() > 0)
            found[found.size()-1].last_of_run = 1'b1;
        foreach (found[i])
            expected_tokens.push_back(found[i]);
    endfunction

    // ------------------------------------------------------------------
    // token side: random stall bursts and the result check
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            tok_stall <= 1'b0;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (idling && $urandom_range(0, 4) == 0)
        begin
            tok_stall <= 1'b1;
            hold_left <= $urandom_range(0, 3);
        end
        else
            tok_stall <= 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] want);
        $display("%0t: token %0d %s: got %0h, expected %0h",
                 $realtime, tokens_checked, what, seen, want);
        mismatches++;
    endtask

    task automatic compare_token(input out_item_t seen);
        out_item_t want;
        if (expected_tokens.size() == 0)
        begin
            report_mismatch("arrived with none expected, kind", 32'(seen.token_kind), 32'd0);
            return;
        end
        want = expected_tokens.pop_front();
        if (seen.token_kind !== want.token_kind)
            report_mismatch("token_kind", 32'(seen.token_kind), 32'(want.token_kind));
        if (seen.start_line !== want.start_line)
            report_mismatch("start_line", 32'(seen.start_line), 32'(want.start_line));
        if (seen.start_col !== want.start_col)
            report_mismatch("start_col", 32'(seen.start_col), 32'(want.start_col));
        if (seen.token_length !== want.token_length)
            report_mismatch("token_length", 32'(seen.token_length), 32'(want.token_length));
        if (seen.length_clipped !== want.length_clipped)
            report_mismatch("length_clipped", 32'(seen.length_clipped),
                            32'(want.length_clipped));
        if (seen.first_char !== want.first_char)
            report_mismatch("first_char", 32'(seen.first_char), 32'(want.first_char));
        if (seen.second_char !== want.second_char)
            report_mismatch("second_char", 32'(seen.second_char), 32'(want.second_char));
        if (seen.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", 32'(seen.last_of_run), 32'(want.last_of_run));
        tokens_checked++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && tok_valid && !tok_stall)
            compare_token(tok_item);
    end

    // ------------------------------------------------------------------
    // source side
    // ------------------------------------------------------------------
    // drive one item at a falling edge, hold it until an edge with no stall takes it;
    // the task returns at that edge so the next call drives at the following fall
    task automatic send_item(input logic [7:0] c, input logic eot);
        in_item_t it;
        int       gap;
        it.char_code   = c;
        it.end_of_text = eot;
        @(negedge clk);
        if (idling && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 4);
            src_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        src_item  <= it;
        src_valid <= 1'b1;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        tokenize_char(it);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    // drop valid and hold off until every owed token has come out
    task automatic pause_source();
        @(negedge clk);
        src_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // random source text
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_letter();
        int k;
        k = $urandom_range(0, 52);
        if (k < 26)
            return CHAR_LOWER_A + 8'(k);
        else if (k < 52)
            return CHAR_UPPER_A + 8'(k - 26);
        return CHAR_UNDERSCORE;
    endfunction

    function automatic logic [7:0] pick_digit();
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 7))
            0:       return CHAR_PLUS;
            1:       return CHAR_MINUS;
            2:       return CHAR_STAR;
            3:       return CHAR_SLASH;
            4:       return CHAR_EQ;
            5:       return CHAR_LT;
            6:       return CHAR_GT;
            default: return CHAR_BANG;
        endcase
    endfunction

    // one lexeme: mostly well-formed tokens with random content, some noise and end marks
    task automatic send_random_lexeme();
        int         pick;
        int         len;
        logic [7:0] q;
        string      marks;
        marks = "(){}[];,.:#$%&?@^|~";
        pick = $urandom_range(0, 99);
        if (pick < 24)
        begin
            send_item(pick_letter(), 1'b0);
            len = $urandom_range(0, 7);
            repeat (len) send_item(($urandom_range(0, 3) == 0) ? pick_digit() : pick_letter(),
                                   1'b0);
        end
        else if (pick < 38)
        begin
            send_item(pick_digit(), 1'b0);
            len = $urandom_range(0, 5);
            repeat (len) send_item(($urandom_range(0, 3) == 0) ? CHAR_DOT : pick_digit(), 1'b0);
        end
        else if (pick < 50)
        begin
            send_item(pick_op(), 1'b0);
            if ($urandom_range(0, 1) == 1)
                send_item(pick_op(), 1'b0);
        end
        else if (pick < 62)
        begin
            q = ($urandom_range(0, 1) == 1) ? CHAR_DQUOTE : CHAR_SQUOTE;
            send_item(q, 1'b0);
            len = $urandom_range(0, 8);
            repeat (len)
            begin
                case ($urandom_range(0, 5))
                    0:
                    begin
                        send_item(CHAR_BACKSLASH, 1'b0);
                        send_item(8'($urandom_range(0, 255)), 1'b0);
                    end
                    1:       send_item(CHAR_NEWLINE, 1'b0);
                    2:       send_item((q == CHAR_DQUOTE) ? CHAR_SQUOTE : CHAR_DQUOTE, 1'b0);
                    default: send_item(8'($urandom_range(32, 126)), 1'b0);
                endcase
            end
            // now and then leave the string open for the next lexeme or end mark
            if ($urandom_range(0, 9) != 0)
                send_item(q, 1'b0);
        end
        else if (pick < 78)
        begin
            case ($urandom_range(0, 3))
                0:       send_item(CHAR_SPACE, 1'b0);
                1:       send_item(CHAR_TAB, 1'b0);
                2:       send_item(CHAR_CR, 1'b0);
                default: send_item(CHAR_NEWLINE, 1'b0);
            endcase
        end
        else if (pick < 86)
            send_item(marks[$urandom_range(0, marks.len() - 1)], 1'b0);
        else if (pick < 97)
            send_item(8'($urandom_range(0, 255)), 1'b0);
        else
            send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic random_stream(input int count, input logic with_idle);
        int first;
        first = chars_sent;
        idling = with_idle;
        while (chars_sent - first < count)
        begin
            // quiet stretches inside the idling part
            if (with_idle && $urandom_range(0, 29) == 0)
                idling = ($urandom_range(0, 3) != 0);
            send_random_lexeme();
            if ($urandom_range(0, 299) == 0)
                pause_source();
        end
        pause_source();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        idling = 1'b1;
        // name, number closed by an operator, two- and one-char operators,
        // then a name closed by punctuation which gives two tokens
        send_text("_aZ9 0.9!=-x;");
        // byte zero and a byte above 127 are punctuation
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CHAR_NEWLINE, 1'b0);
        // empty string, then end mark just after a backslash in a string
        send_text("''\"a\\");
        send_item(8'hA5, 1'b1);
        // end mark inside a string
        send_text("'q");
        send_item(8'h00, 1'b1);
        // end mark with nothing open
        send_item(CHAR_UPPER_Z, 1'b1);
        pause_source();
    endtask

    task automatic test_random_mix();
        random_stream(1100, 1'b1);
    endtask

    task automatic test_quiet_stream();
        random_stream(250, 1'b0);
    endtask

    initial
    begin
        clear_lexer();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_mix();
        test_quiet_stream();

        pause_source();
        idling = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d tokens from %0d source items in %0d cycles",
                 tokens_checked, chars_sent, cycle_count);
        $display("covered all token kinds, escapes and open strings, and end marks on open tokens");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/sct_pkg.sv
hdl/sct_scan.sv
hdl/sct_out_queue.sv
hdl/script_char_tokenizer_top.sv
hdl/sct_checker.sv
tb/script_char_tokenizer_top_test.sv
